[hw/rtl/lbmpsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lbmpsm_pkg;

	// Q4.44 value and wide sum
	typedef logic signed [47:0] q_t;
	typedef logic signed [53:0] w_t;
	typedef logic [3:0] dir_t;
	typedef logic signed [1:0] unit_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_TAU  = 1'b0,
		CFG_GRAV = 1'b1
	} cfg_idx_t;

	// lattice directions
	localparam dir_t DIR_REST = 4'd0;
	localparam dir_t DIR_E    = 4'd1;
	localparam dir_t DIR_N    = 4'd2;
	localparam dir_t DIR_W    = 4'd3;
	localparam dir_t DIR_S    = 4'd4;
	localparam dir_t DIR_NE   = 4'd5;
	localparam dir_t DIR_NW   = 4'd6;
	localparam dir_t DIR_SW   = 4'd7;
	localparam dir_t DIR_SE   = 4'd8;

	localparam q_t MAXQ     = 48'sh7FFFFFFFFFFF;
	localparam q_t MINQ     = 48'sh800000000000;
	localparam q_t ONE_Q    = 48'sd17592186044416;
	localparam q_t HALF_Q   = 48'sd8796093022208;
	localparam q_t C4P5_Q   = 48'sd79164837199872;
	localparam q_t C1P5_Q   = 48'sd26388279066624;
	localparam q_t W_REST_Q = 48'sd7818749353074;
	localparam q_t W_AXIS_Q = 48'sd1954687338268;
	localparam q_t W_DIAG_Q = 48'sd488671834567;

	localparam logic [45:0] TAU_RST = 46'd9323858603540;
	localparam logic signed [45:0] GRAV_RST = -46'sd6157265;

	// one quotient bit per divider stage
	localparam int DIV_STEPS = 48;

	// split product: four 24x24 partial products of the magnitudes
	typedef struct packed {
		logic neg;
		logic [47:0] ll;
		logic [47:0] lh;
		logic [47:0] hl;
		logic [47:0] hh;
	} mul_parts_t;

	// values that travel alongside a division
	typedef struct packed {
		dir_t b;
		logic ovl;
		q_t f;
		q_t fe;
		q_t fdiff;
		q_t omega;
		q_t dot;
		q_t bo;
		q_t fterm;
	} side_t;

	function automatic unit_t dir_ex(dir_t b);
		unit_t r;
		case (b) inside
			DIR_E, DIR_NE, DIR_SE: r = 2'sd1;
			DIR_W, DIR_NW, DIR_SW: r = -2'sd1;
			default: r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic unit_t dir_ey(dir_t b);
		unit_t r;
		case (b) inside
			DIR_N, DIR_NE, DIR_NW: r = 2'sd1;
			DIR_S, DIR_SW, DIR_SE: r = -2'sd1;
			default: r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic q_t dir_w(dir_t b);
		q_t r;
		case (b) inside
			DIR_E, DIR_N, DIR_W, DIR_S: r = W_AXIS_Q;
			DIR_NE, DIR_NW, DIR_SW, DIR_SE: r = W_DIAG_Q;
			default: r = W_REST_Q;
		endcase
		return r;
	endfunction

	function automatic w_t wide(q_t a);
		return {{6{a[47]}}, a};
	endfunction

	function automatic q_t sat(w_t v);
		q_t r;
		if (v > wide(MAXQ)) r = MAXQ;
		else if (v < wide(MINQ)) r = MINQ;
		else r = q_t'(v[47:0]);
		return r;
	endfunction

	// unit direction component times a value
	function automatic w_t scale(unit_t e, q_t a);
		w_t r;
		if (e == 2'sd1) r = wide(a);
		else if (e == -2'sd1) r = -wide(a);
		else r = '0;
		return r;
	endfunction

	function automatic logic [47:0] mag(q_t a);
		logic [47:0] r;
		r = a[47] ? (~a + 48'd1) : a;
		return r;
	endfunction

	// signed result of a magnitude, saturated to Q4.44
	function automatic q_t sat_mag(logic [51:0] m, logic neg);
		logic [47:0] t;
		q_t r;
		t = ~m[47:0] + 48'd1;
		if (neg) begin
			if (m >= 52'h0800000000000) r = MINQ;
			else r = q_t'(t);
		end else begin
			if (m > 52'h07FFFFFFFFFFF) r = MAXQ;
			else r = q_t'(m[47:0]);
		end
		return r;
	endfunction

	function automatic mul_parts_t mul_parts(q_t a, q_t b);
		mul_parts_t r;
		logic [47:0] x;
		logic [47:0] y;
		x = mag(a);
		y = mag(b);
		r.neg = a[47] ^ b[47];
		r.ll = 48'(x[23:0]) * 48'(y[23:0]);
		r.lh = 48'(x[23:0]) * 48'(y[47:24]);
		r.hl = 48'(x[47:24]) * 48'(y[23:0]);
		r.hh = 48'(x[47:24]) * 48'(y[47:24]);
		return r;
	endfunction

	// sum partials, round half away from zero, saturate
	function automatic q_t mul_fin(mul_parts_t p);
		logic [95:0] s;
		s = {48'd0, p.ll} + ({48'd0, p.lh} << 24) + ({48'd0, p.hl} << 24)
			+ {p.hh, 48'd0} + (96'd1 << 43);
		return sat_mag(s[95:44], p.neg);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/lbmpsm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface lbmpsm_in_if import lbmpsm_pkg::*; ();
	logic valid;
	logic ready;
	dir_t direction;
	q_t dist_value;
	q_t dist_opposite;
	logic [46:0] density;
	q_t vel_x;
	q_t vel_y;
	logic overlap;
	logic [44:0] solid_fraction;
	q_t particle_vel_x;
	q_t particle_vel_y;

	modport source (output valid, direction, dist_value, dist_opposite, density, vel_x,
		vel_y, overlap, solid_fraction, particle_vel_x, particle_vel_y, input ready);
	modport sink (input valid, direction, dist_value, dist_opposite, density, vel_x,
		vel_y, overlap, solid_fraction, particle_vel_x, particle_vel_y, output ready);
endinterface
`default_nettype wire

[hw/rtl/lbmpsm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface lbmpsm_out_if import lbmpsm_pkg::*; ();
	logic valid;
	logic ready;
	q_t post_value;
	q_t drag_x_part;
	q_t drag_y_part;

	modport source (output valid, post_value, drag_x_part, drag_y_part, input ready);
	modport sink (input valid, post_value, drag_x_part, drag_y_part, output ready);
endinterface
`default_nettype wire

[hw/rtl/lbmpsm_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface lbmpsm_cfg_if ();
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [45:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/lbmpsm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module lbmpsm_div import lbmpsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid,
	input  q_t    num,
	input  q_t    den,
	input  side_t tag,
	output logic  res_valid,
	output q_t    quot,
	output side_t res_tag
);

	typedef struct packed {
		logic [47:0] rem;
		logic [47:0] q;
		logic [47:0] d;
		logic [3:0] nlo;
		logic neg;
		logic ovf;
		logic dz;
		logic nzero;
	} stage_t;

	stage_t st_s [DIV_STEPS+1];
	stage_t st_nxt [1:DIV_STEPS];
	side_t tag_s [DIV_STEPS+1];
	logic [DIV_STEPS:0] vld_s;

	logic [47:0] n_mag;
	logic [47:0] d_mag;
	stage_t prep;
	logic [51:0] q_ext;

	// magnitudes, overflow check and first partial remainder
	always_comb begin
		n_mag = mag(num);
		d_mag = mag(den);
		prep.rem = {4'd0, n_mag[47:4]};
		prep.q = '0;
		prep.d = d_mag;
		prep.nlo = n_mag[3:0];
		prep.neg = num[47] ^ den[47];
		prep.ovf = {4'd0, n_mag} >= {d_mag, 4'd0};
		prep.dz = (den == '0);
		prep.nzero = (num == '0);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_STEPS-1:0], valid};
		end
	end

	// one restoring step per stage, quotient msb first
	always_comb begin
		logic [48:0] trial;
		logic [49:0] diff;
		for (int k = 1; k <= DIV_STEPS; k++) begin
			trial = {st_s[k-1].rem, st_s[k-1].nlo[3]};
			diff = {1'b0, trial} - {2'd0, st_s[k-1].d};
			st_nxt[k] = st_s[k-1];
			st_nxt[k].nlo = {st_s[k-1].nlo[2:0], 1'b0};
			st_nxt[k].rem = diff[49] ? trial[47:0] : diff[47:0];
			st_nxt[k].q = {st_s[k-1].q[46:0], ~diff[49]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= prep;
			tag_s[0] <= tag;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				st_s[k] <= st_nxt[k];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	// sign and saturation, zero divisor goes to the numerator's sign
	always_comb begin
		q_ext = st_s[DIV_STEPS].ovf ? '1 : {4'd0, st_s[DIV_STEPS].q};
		if (st_s[DIV_STEPS].dz && st_s[DIV_STEPS].nzero) quot = '0;
		else quot = sat_mag(q_ext, st_s[DIV_STEPS].neg);
	end

	assign res_valid = vld_s[DIV_STEPS];
	assign res_tag = tag_s[DIV_STEPS];

endmodule
`default_nettype wire

[hw/rtl/lbm_d2q9_psm_collision.sv]
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle when not stalled; the 48-step dividers set the depth
// a stall on the result side freezes every stage; nothing is lost or repeated
// reset clears all valid bits and loads tau = 0.53 and gravity = -3.5e-7
// configuration writes are taken in any cycle
module lbm_d2q9_psm_collision import lbmpsm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lbmpsm_in_if.sink    items_in,
	lbmpsm_out_if.source results,
	lbmpsm_cfg_if.sink   cfg
);

	logic [45:0] tau_q;
	logic [45:0] grav_q;
	q_t tau_v;
	q_t grav_v;
	logic adv;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q <= TAU_RST;
			grav_q <= GRAV_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TAU: tau_q <= cfg.data;
				CFG_GRAV: grav_q <= cfg.data;
				default: tau_q <= tau_q;
			endcase
		end
	end

	assign tau_v = q_t'({2'd0, tau_q});
	assign grav_v = q_t'({{2{grav_q[45]}}, grav_q});

	// whole pipeline moves unless the result register is held
	assign adv = !results.valid || results.ready;
	assign items_in.ready = adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic beta_vld, coef_vld, relax_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= '0;
			{vld_s6, vld_s7, vld_s8, vld_s9, vld_s10} <= '0;
			{vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16} <= '0;
		end else if (adv) begin
			vld_s1 <= items_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= beta_vld;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= relax_vld;
		end
	end

	// stage 1: input register
	dir_t b_s1;
	q_t f_s1, fo_s1, rho_s1, ux_s1, uy_s1, es_s1, px_s1, py_s1;
	logic ovl_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1 <= items_in.direction;
			f_s1 <= items_in.dist_value;
			fo_s1 <= items_in.dist_opposite;
			rho_s1 <= q_t'({1'b0, items_in.density});
			ux_s1 <= items_in.vel_x;
			uy_s1 <= items_in.vel_y;
			ovl_s1 <= items_in.overlap;
			es_s1 <= q_t'({3'd0, items_in.solid_fraction});
			px_s1 <= items_in.particle_vel_x;
			py_s1 <= items_in.particle_vel_y;
		end
	end

	// stage 2: projections on e, squares of velocities started
	w_t eu_raw, ep_raw;
	assign eu_raw = scale(dir_ex(b_s1), ux_s1) + scale(dir_ey(b_s1), uy_s1);
	assign ep_raw = scale(dir_ex(b_s1), px_s1) + scale(dir_ey(b_s1), py_s1);

	dir_t b_s2;
	q_t f_s2, fo_s2, eu_s2, euo_s2, ep_s2, den_s2, tmh_s2, es_s2, ydiff_s2;
	logic ovl_s2;
	mul_parts_t m_uxx_s2, m_uyy_s2, m_pxx_s2, m_pyy_s2, m_wr_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s2 <= b_s1;
			f_s2 <= f_s1;
			fo_s2 <= fo_s1;
			ovl_s2 <= ovl_s1;
			es_s2 <= es_s1;
			eu_s2 <= sat(eu_raw);
			euo_s2 <= sat(-eu_raw);
			ep_s2 <= sat(ep_raw);
			den_s2 <= sat(wide(tau_v) + wide(HALF_Q) - wide(es_s1));
			tmh_s2 <= sat(wide(tau_v) - wide(HALF_Q));
			ydiff_s2 <= sat(scale(dir_ey(b_s1), ONE_Q) - wide(uy_s1));
			m_uxx_s2 <= mul_parts(ux_s1, ux_s1);
			m_uyy_s2 <= mul_parts(uy_s1, uy_s1);
			m_pxx_s2 <= mul_parts(px_s1, px_s1);
			m_pyy_s2 <= mul_parts(py_s1, py_s1);
			m_wr_s2 <= mul_parts(dir_w(b_s1), rho_s1);
		end
	end

	// stage 3: finish squares, start e.u squared, beta numerator, gravity dot
	dir_t b_s3;
	q_t f_s3, fo_s3, eu_s3, euo_s3, ep_s3, den_s3;
	q_t uxx_s3, uyy_s3, pxx_s3, pyy_s3, wr_s3;
	logic ovl_s3;
	mul_parts_t m_e2_s3, m_e2o_s3, m_ep2_s3, m_num_s3, m_dot_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3 <= b_s2;
			f_s3 <= f_s2;
			fo_s3 <= fo_s2;
			ovl_s3 <= ovl_s2;
			eu_s3 <= eu_s2;
			euo_s3 <= euo_s2;
			ep_s3 <= ep_s2;
			den_s3 <= den_s2;
			uxx_s3 <= mul_fin(m_uxx_s2);
			uyy_s3 <= mul_fin(m_uyy_s2);
			pxx_s3 <= mul_fin(m_pxx_s2);
			pyy_s3 <= mul_fin(m_pyy_s2);
			wr_s3 <= mul_fin(m_wr_s2);
			m_e2_s3 <= mul_parts(eu_s2, eu_s2);
			m_e2o_s3 <= mul_parts(euo_s2, euo_s2);
			m_ep2_s3 <= mul_parts(ep_s2, ep_s2);
			m_num_s3 <= mul_parts(es_s2, tmh_s2);
			m_dot_s3 <= mul_parts(ydiff_s2, grav_v);
		end
	end

	// stage 4: finish products, |u|^2 sums
	dir_t b_s4;
	q_t f_s4, fo_s4, eu_s4, euo_s4, ep_s4, den_s4, wr_s4;
	q_t e2_s4, e2o_s4, ep2_s4, num_s4, dot_s4, usq_s4, psq_s4;
	logic ovl_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s4 <= b_s3;
			f_s4 <= f_s3;
			fo_s4 <= fo_s3;
			ovl_s4 <= ovl_s3;
			eu_s4 <= eu_s3;
			euo_s4 <= euo_s3;
			ep_s4 <= ep_s3;
			den_s4 <= den_s3;
			wr_s4 <= wr_s3;
			e2_s4 <= mul_fin(m_e2_s3);
			e2o_s4 <= mul_fin(m_e2o_s3);
			ep2_s4 <= mul_fin(m_ep2_s3);
			num_s4 <= mul_fin(m_num_s3);
			dot_s4 <= mul_fin(m_dot_s3);
			usq_s4 <= sat(wide(uxx_s3) + wide(uyy_s3));
			psq_s4 <= sat(wide(pxx_s3) + wide(pyy_s3));
		end
	end

	// stage 5: start 4.5*(e.u)^2 and 1.5*|u|^2
	dir_t b_s5;
	q_t f_s5, fo_s5, eu_s5, euo_s5, ep_s5, den_s5, wr_s5, num_s5, dot_s5;
	logic ovl_s5;
	mul_parts_t m_au_s5, m_ao_s5, m_ap_s5, m_bu_s5, m_bp_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s5 <= b_s4;
			f_s5 <= f_s4;
			fo_s5 <= fo_s4;
			ovl_s5 <= ovl_s4;
			eu_s5 <= eu_s4;
			euo_s5 <= euo_s4;
			ep_s5 <= ep_s4;
			den_s5 <= den_s4;
			wr_s5 <= wr_s4;
			num_s5 <= num_s4;
			dot_s5 <= dot_s4;
			m_au_s5 <= mul_parts(C4P5_Q, e2_s4);
			m_ao_s5 <= mul_parts(C4P5_Q, e2o_s4);
			m_ap_s5 <= mul_parts(C4P5_Q, ep2_s4);
			m_bu_s5 <= mul_parts(C1P5_Q, usq_s4);
			m_bp_s5 <= mul_parts(C1P5_Q, psq_s4);
		end
	end

	// stage 6: finish polynomial terms
	dir_t b_s6;
	q_t f_s6, fo_s6, eu_s6, euo_s6, ep_s6, den_s6, wr_s6, num_s6, dot_s6;
	q_t au_s6, ao_s6, ap_s6, bu_s6, bp_s6;
	logic ovl_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s6 <= b_s5;
			f_s6 <= f_s5;
			fo_s6 <= fo_s5;
			ovl_s6 <= ovl_s5;
			eu_s6 <= eu_s5;
			euo_s6 <= euo_s5;
			ep_s6 <= ep_s5;
			den_s6 <= den_s5;
			wr_s6 <= wr_s5;
			num_s6 <= num_s5;
			dot_s6 <= dot_s5;
			au_s6 <= mul_fin(m_au_s5);
			ao_s6 <= mul_fin(m_ao_s5);
			ap_s6 <= mul_fin(m_ap_s5);
			bu_s6 <= mul_fin(m_bu_s5);
			bp_s6 <= mul_fin(m_bp_s5);
		end
	end

	// stage 7: equilibrium polynomials for fluid, opposite and particle
	dir_t b_s7;
	q_t f_s7, fo_s7, den_s7, wr_s7, num_s7, dot_s7;
	q_t poly_u_s7, poly_o_s7, poly_p_s7;
	logic ovl_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s7 <= b_s6;
			f_s7 <= f_s6;
			fo_s7 <= fo_s6;
			ovl_s7 <= ovl_s6;
			den_s7 <= den_s6;
			wr_s7 <= wr_s6;
			num_s7 <= num_s6;
			dot_s7 <= dot_s6;
			poly_u_s7 <= sat(wide(ONE_Q) + wide(eu_s6) + (wide(eu_s6) <<< 1)
				+ wide(au_s6) - wide(bu_s6));
			poly_o_s7 <= sat(wide(ONE_Q) + wide(euo_s6) + (wide(euo_s6) <<< 1)
				+ wide(ao_s6) - wide(bu_s6));
			poly_p_s7 <= sat(wide(ONE_Q) + wide(ep_s6) + (wide(ep_s6) <<< 1)
				+ wide(ap_s6) - wide(bp_s6));
		end
	end

	// stage 8: start w*rho*poly
	dir_t b_s8;
	q_t f_s8, fo_s8, den_s8, num_s8, dot_s8;
	logic ovl_s8;
	mul_parts_t m_fe_s8, m_feo_s8, m_fep_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s8 <= b_s7;
			f_s8 <= f_s7;
			fo_s8 <= fo_s7;
			ovl_s8 <= ovl_s7;
			den_s8 <= den_s7;
			num_s8 <= num_s7;
			dot_s8 <= dot_s7;
			m_fe_s8 <= mul_parts(wr_s7, poly_u_s7);
			m_feo_s8 <= mul_parts(wr_s7, poly_o_s7);
			m_fep_s8 <= mul_parts(wr_s7, poly_p_s7);
		end
	end

	// stage 9: equilibria
	dir_t b_s9;
	q_t f_s9, fo_s9, den_s9, num_s9, dot_s9, fe_s9, feo_s9, fep_s9;
	logic ovl_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s9 <= b_s8;
			f_s9 <= f_s8;
			fo_s9 <= fo_s8;
			ovl_s9 <= ovl_s8;
			den_s9 <= den_s8;
			num_s9 <= num_s8;
			dot_s9 <= dot_s8;
			fe_s9 <= mul_fin(m_fe_s8);
			feo_s9 <= mul_fin(m_feo_s8);
			fep_s9 <= mul_fin(m_fep_s8);
		end
	end

	// stage 10: non-equilibrium part and interaction term
	dir_t b_s10;
	q_t f_s10, fe_s10, den_s10, num_s10, dot_s10, fdiff_s10, omega_s10;
	logic ovl_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s10 <= b_s9;
			f_s10 <= f_s9;
			fe_s10 <= fe_s9;
			ovl_s10 <= ovl_s9;
			den_s10 <= den_s9;
			num_s10 <= num_s9;
			dot_s10 <= dot_s9;
			fdiff_s10 <= sat(wide(f_s9) - wide(fe_s9));
			omega_s10 <= sat(wide(fo_s9) - wide(f_s9) + wide(fep_s9) - wide(feo_s9));
		end
	end

	// beta = num / den and forcing coefficient 1/(2 tau), side by side
	side_t beta_tag, beta_tag_out, relax_tag, relax_tag_out;
	q_t beta_quot, coef_quot, relax_quot;

	always_comb begin
		beta_tag = '0;
		beta_tag.b = b_s10;
		beta_tag.ovl = ovl_s10;
		beta_tag.f = f_s10;
		beta_tag.fe = fe_s10;
		beta_tag.fdiff = fdiff_s10;
		beta_tag.omega = omega_s10;
		beta_tag.dot = dot_s10;
	end

	lbmpsm_div u_beta_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid     (vld_s10),
		.num       (num_s10),
		.den       (den_s10),
		.tag       (beta_tag),
		.res_valid (beta_vld),
		.quot      (beta_quot),
		.res_tag   (beta_tag_out)
	);

	lbmpsm_div u_coef_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid     (vld_s10),
		.num       (HALF_Q),
		.den       (tau_v),
		.tag       ('0),
		.res_valid (coef_vld),
		.quot      (coef_quot),
		.res_tag   ()
	);

	// stage 11: beta forced to zero for fluid cells, 1-beta and 1-coef formed
	dir_t b_s11;
	q_t f_s11, fe_s11, fdiff_s11, omega_s11, dot_s11, beta_s11, omb_s11, coef_s11;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s11 <= beta_tag_out.b;
			f_s11 <= beta_tag_out.f;
			fe_s11 <= beta_tag_out.fe;
			fdiff_s11 <= beta_tag_out.fdiff;
			omega_s11 <= beta_tag_out.omega;
			dot_s11 <= beta_tag_out.dot;
			beta_s11 <= beta_tag_out.ovl ? beta_quot : '0;
			omb_s11 <= sat(wide(ONE_Q) - wide(beta_tag_out.ovl ? beta_quot : q_t'(0)));
			coef_s11 <= sat(wide(ONE_Q) - wide(coef_quot));
		end
	end

	// stage 12: start (1-beta)*fdiff, beta*omega, coef*dot
	dir_t b_s12;
	q_t f_s12, fe_s12;
	mul_parts_t m_x_s12, m_bo_s12, m_cd_s12;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s12 <= b_s11;
			f_s12 <= f_s11;
			fe_s12 <= fe_s11;
			m_x_s12 <= mul_parts(omb_s11, fdiff_s11);
			m_bo_s12 <= mul_parts(beta_s11, omega_s11);
			m_cd_s12 <= mul_parts(coef_s11, dot_s11);
		end
	end

	// stage 13
	dir_t b_s13;
	q_t f_s13, fe_s13, x_s13, bo_s13, cd_s13;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s13 <= b_s12;
			f_s13 <= f_s12;
			fe_s13 <= fe_s12;
			x_s13 <= mul_fin(m_x_s12);
			bo_s13 <= mul_fin(m_bo_s12);
			cd_s13 <= mul_fin(m_cd_s12);
		end
	end

	// stage 14: start 3*coef*dot times feq
	dir_t b_s14;
	q_t f_s14, x_s14, bo_s14;
	mul_parts_t m_ft_s14;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s14 <= b_s13;
			f_s14 <= f_s13;
			x_s14 <= x_s13;
			bo_s14 <= bo_s13;
			m_ft_s14 <= mul_parts(sat(wide(cd_s13) + (wide(cd_s13) <<< 1)), fe_s13);
		end
	end

	// stage 15: forcing term
	dir_t b_s15;
	q_t f_s15, x_s15, bo_s15, fterm_s15;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s15 <= b_s14;
			f_s15 <= f_s14;
			x_s15 <= x_s14;
			bo_s15 <= bo_s14;
			fterm_s15 <= mul_fin(m_ft_s14);
		end
	end

	// relaxation term divided by tau
	always_comb begin
		relax_tag = '0;
		relax_tag.b = b_s15;
		relax_tag.f = f_s15;
		relax_tag.bo = bo_s15;
		relax_tag.fterm = fterm_s15;
	end

	lbmpsm_div u_relax_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid     (vld_s15),
		.num       (x_s15),
		.den       (tau_v),
		.tag       (relax_tag),
		.res_valid (relax_vld),
		.quot      (relax_quot),
		.res_tag   (relax_tag_out)
	);

	// stage 16: result register
	q_t post_s16, dx_s16, dy_s16;
	always_ff @(posedge clk) begin
		if (adv) begin
			post_s16 <= sat(wide(relax_tag_out.f) - wide(relax_quot)
				+ wide(relax_tag_out.bo) + wide(relax_tag_out.fterm));
			dx_s16 <= sat(scale(dir_ex(relax_tag_out.b), relax_tag_out.bo));
			dy_s16 <= sat(scale(dir_ey(relax_tag_out.b), relax_tag_out.bo));
		end
	end

	assign results.valid = vld_s16;
	assign results.post_value = post_s16;
	assign results.drag_x_part = dx_s16;
	assign results.drag_y_part = dy_s16;

	// the two parallel dividers stay in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		coef_vld == beta_vld)
		else $error("beta and coefficient dividers out of step");

	// a held result freezes the middle of the pipeline
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s12) && $stable(vld_s5))
		else $error("pipeline moved during a stall");

	// an item moving out of stage 13 lands in stage 14
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s13 |=> vld_s14)
		else $error("item lost between stages 13 and 14");

endmodule
`default_nettype wire
